FILE: rtl/core/cmbc_pkg.sv
// Shared types, register map and inverse table for the chained multiplicative byte cipher.
package cmbc_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;
    localparam int unsigned InvDepth = 128;

    localparam logic [ByteW-1:0] InitKeyReset = 8'd1;
    localparam logic [ByteW-1:0] AlphaReset   = 8'd0;
    localparam logic             DecryptReset = 1'b0;
    localparam logic [ByteW-1:0] ChainKeyReset = 8'd1;

    typedef enum logic [1:0] {
        REG_DECRYPT_MODE = 2'd0,
        REG_INITIAL_KEY  = 2'd1,
        REG_OFFSET_ALPHA = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [ByteW-1:0] data_in;
        logic             first_byte;
    } t_in_item;

    typedef struct packed {
        logic [ByteW-1:0] data_out;
        logic [ByteW-1:0] key_out;
    } t_out_item;

    typedef struct packed {
        logic             decrypt_mode;
        logic [ByteW-1:0] initial_key;
        logic [ByteW-1:0] offset_alpha;
    } t_cfg;

    localparam logic [ByteW-1:0] OddInverse [InvDepth] = '{
        8'd1,   8'd171, 8'd205, 8'd183, 8'd57,  8'd163, 8'd197, 8'd239,
        8'd241, 8'd27,  8'd61,  8'd167, 8'd41,  8'd19,  8'd53,  8'd223,
        8'd225, 8'd139, 8'd173, 8'd151, 8'd25,  8'd131, 8'd165, 8'd207,
        8'd209, 8'd251, 8'd29,  8'd135, 8'd9,   8'd243, 8'd21,  8'd191,
        8'd193, 8'd107, 8'd141, 8'd119, 8'd249, 8'd99,  8'd133, 8'd175,
        8'd177, 8'd219, 8'd253, 8'd103, 8'd233, 8'd211, 8'd245, 8'd159,
        8'd161, 8'd75,  8'd109, 8'd87,  8'd217, 8'd67,  8'd101, 8'd143,
        8'd145, 8'd187, 8'd221, 8'd71,  8'd201, 8'd179, 8'd213, 8'd127,
        8'd129, 8'd43,  8'd77,  8'd55,  8'd185, 8'd35,  8'd69,  8'd111,
        8'd113, 8'd155, 8'd189, 8'd39,  8'd169, 8'd147, 8'd181, 8'd95,
        8'd97,  8'd11,  8'd45,  8'd23,  8'd153, 8'd3,   8'd37,  8'd79,
        8'd81,  8'd123, 8'd157, 8'd7,   8'd137, 8'd115, 8'd149, 8'd63,
        8'd65,  8'd235, 8'd13,  8'd247, 8'd121, 8'd227, 8'd5,   8'd47,
        8'd49,  8'd91,  8'd125, 8'd231, 8'd105, 8'd83,  8'd117, 8'd31,
        8'd33,  8'd203, 8'd237, 8'd215, 8'd89,  8'd195, 8'd229, 8'd15,
        8'd17,  8'd59,  8'd93,  8'd199, 8'd73,  8'd51,  8'd85,  8'd255
    };

endpackage

FILE: rtl/core/chained_multiplicative_byte_cipher_unit.sv
// Top level of the chained multiplicative byte cipher with its pipeline registers.
//
// Each accepted byte lands in an input register, passes through the cipher logic
// and is held in a result register. A result is presented once it moves from the
// input register into the result register, which loads when empty or when its result is taken.
// One byte is taken every cycle while the output is not stalled. The chain-key loop
// sets the throughput: key select and, in decrypt mode, the offset subtract and one
// 8-bit multiply. Setting first_byte reloads the key from the initial key register;
// after reset the chain key is 1. Write configuration only while idle.
module chained_multiplicative_byte_cipher_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  cmbc_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cmbc_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmbc_pkg::AddrW-1:0]  paddr,
    input  logic [cmbc_pkg::DataW-1:0]  pwdata,
    output logic [cmbc_pkg::DataW-1:0]  prdata,
    output logic                        pready
);
    import cmbc_pkg::*;

    t_cfg             w_cfg;
    t_out_item        w_res;
    logic             w_move;
    logic             w_take;
    logic             r_in_vld;
    t_in_item         r_in;
    logic             r_out_vld;
    t_out_item        r_out;
    logic [ByteW-1:0] r_chain_key;

    cmbc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cmbc_cipher u_cipher (
        .i_cfg       (w_cfg),
        .i_chain_key (r_chain_key),
        .i_item      (r_in),
        .o_item      (w_res)
    );

    assign w_move      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_in_vld && !w_move;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_chain_key <= ChainKeyReset;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_move) begin
                r_in_vld <= 1'b0;
            end
            if (w_move) begin
                r_out_vld   <= 1'b1;
                r_chain_key <= w_res.key_out;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in_data;
        end
        if (w_move) begin
            r_out <= w_res;
        end
    end

endmodule

FILE: rtl/core/cmbc_regs.sv
// APB configuration registers of the byte cipher.
module cmbc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmbc_pkg::AddrW-1:0]  paddr,
    input  logic [cmbc_pkg::DataW-1:0]  pwdata,
    output logic [cmbc_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    output cmbc_pkg::t_cfg              o_cfg
);
    import cmbc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_DECRYPT_MODE: n_cfg.decrypt_mode = pwdata[0];
                REG_INITIAL_KEY:  n_cfg.initial_key  = pwdata[ByteW-1:0];
                REG_OFFSET_ALPHA: n_cfg.offset_alpha = pwdata[ByteW-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DECRYPT_MODE: prdata = {{(DataW-1){1'b0}}, r_cfg.decrypt_mode};
            REG_INITIAL_KEY:  prdata = {{(DataW-ByteW){1'b0}}, r_cfg.initial_key};
            REG_OFFSET_ALPHA: prdata = {{(DataW-ByteW){1'b0}}, r_cfg.offset_alpha};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decrypt_mode <= DecryptReset;
            r_cfg.initial_key  <= InitKeyReset;
            r_cfg.offset_alpha <= AlphaReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/core/cmbc_cipher.sv
// Combinational encrypt and decrypt of one byte with the chained key update.
module cmbc_cipher (
    input  cmbc_pkg::t_cfg                 i_cfg,
    input  logic [cmbc_pkg::ByteW-1:0]     i_chain_key,
    input  cmbc_pkg::t_in_item             i_item,
    output cmbc_pkg::t_out_item            o_item
);
    import cmbc_pkg::*;

    logic [ByteW-1:0] w_key;
    logic [ByteW-1:0] w_inv;
    logic [ByteW-1:0] w_diff;
    logic [ByteW-1:0] w_dec;
    logic [ByteW-1:0] w_enc_prod;
    logic [ByteW-1:0] w_enc;
    logic [ByteW-1:0] w_plain;

    assign w_key      = i_item.first_byte ? i_cfg.initial_key : i_chain_key;
    assign w_inv      = OddInverse[w_key[ByteW-1:1]];
    assign w_diff     = i_item.data_in - i_cfg.offset_alpha;
    assign w_dec      = w_diff * w_key;
    assign w_enc_prod = i_item.data_in * w_inv;
    assign w_enc      = i_cfg.offset_alpha + w_enc_prod;
    assign w_plain    = i_cfg.decrypt_mode ? w_dec : i_item.data_in;

    assign o_item.data_out = i_cfg.decrypt_mode ? w_dec : w_enc;
    assign o_item.key_out  = {w_plain[ByteW-2:0], 1'b1};

endmodule
